@@ src/macs_pkg.sv @@
`timescale 1ns / 1ps
package macs_pkg;

   localparam int MOTOR_COUNT  = 6;
   localparam int START_TICKS  = 200;
   localparam int SETTLE_TICKS = 60;

   localparam int ANGLE_W      = 28;
   localparam int MOTOR_W      = 3;
   localparam int THROTTLE_W   = 8;

   localparam logic [ANGLE_W-1:0]    ANGLE_MAX    = {ANGLE_W{1'b1}};
   localparam logic [12:0]           REV_UNITS    = 13'd5760;
   localparam logic [8:0]            DEG_PER_REV  = 9'd360;
   localparam logic [THROTTLE_W-1:0] THROTTLE_MAX = 8'd200;

   typedef struct packed {
      logic        sweep_mode;
      logic [6:0]  throttle_begin;
      logic [6:0]  throttle_increment;
      logic [6:0]  throttle_final;
      logic [7:0]  revolutions;
      logic [8:0]  angle_increment;
      logic [15:0] dwell_ticks;
      logic [15:0] sweep_rate;
   } cfg_type;

   typedef struct packed {
      logic [MOTOR_W-1:0]    motor_index;
      logic [THROTTLE_W-1:0] throttle_level;
      logic [ANGLE_W-1:0]    arm_angle;
      logic                  stamp_pulse;
      logic                  done_res;
   } res_type;

endpackage

@@ src/macs_core.sv @@
`timescale 1ns / 1ps
module macs_core
   import macs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    stop_request,
   input  cfg_type cfg,
   output res_type res
);

   localparam logic [3:0] PH_START      = 4'd0;
   localparam logic [3:0] PH_RAMP_UP    = 4'd1;
   localparam logic [3:0] PH_PRE_DWELL  = 4'd2;
   localparam logic [3:0] PH_STEP_DWELL = 4'd3;
   localparam logic [3:0] PH_RAMP_DOWN  = 4'd4;
   localparam logic [3:0] PH_END_WAIT   = 4'd5;
   localparam logic [3:0] PH_DONE       = 4'd6;
   localparam logic [3:0] PH_SETTLE_LOW = 4'd7;
   localparam logic [3:0] PH_SWEEP_UP   = 4'd8;
   localparam logic [3:0] PH_SETTLE_TOP = 4'd9;
   localparam logic [3:0] PH_SWEEP_DOWN = 4'd10;

   logic [3:0]            phase_ff, phase_in;
   logic [MOTOR_W-1:0]    motor_ff, motor_in;
   logic [THROTTLE_W-1:0] throttle_ff, throttle_in;
   logic [THROTTLE_W-1:0] goal_ff, goal_in;
   logic [6:0]            level_ff, level_in;
   logic [7:0]            rev_cnt_ff, rev_cnt_in;
   logic [15:0]           total_revs_ff, total_revs_in;
   logic [24:0]           rev_base_ff, rev_base_in;
   logic [8:0]            step_angle_ff, step_angle_in;
   logic [ANGLE_W-1:0]    sweep_pos_ff, sweep_pos_in;
   logic [15:0]           wait_ff, wait_in;
   logic [ANGLE_W-1:0]    held_ff [MOTOR_COUNT];
   logic [ANGLE_W-1:0]    held_in [MOTOR_COUNT];

   // shared helpers
   logic [15:0]        wait_lim;
   logic               wait_done;
   logic               ramp_done;
   logic [7:0]         ramp_val;
   logic               rev_inc;
   logic [24:0]        rev_base_cur;
   logic [8:0]         pos_angle;
   logic [25:0]        pos_sum;
   logic [ANGLE_W-1:0] step_val;
   logic [15:0]        rate;
   logic [ANGLE_W-1:0] top;
   logic [28:0]        up_sum;
   logic [ANGLE_W-1:0] up_val;
   logic [9:0]         angle_next;
   logic [8:0]         angle_inc;
   logic [7:0]         rev_next;

   // per-tick control
   logic               go_level;
   logic [7:0]         level_pct;
   logic               clr_revs;
   logic               angle_we;
   logic               angle_from_step;
   logic [ANGLE_W-1:0] angle_wd;
   logic               clr_angles;
   logic               stamp;

   always_comb begin
      case (phase_ff)
         PH_START, PH_END_WAIT:       wait_lim = 16'(START_TICKS);
         PH_SETTLE_LOW, PH_SETTLE_TOP: wait_lim = 16'(SETTLE_TICKS);
         default:                     wait_lim = cfg.dwell_ticks;
      endcase
      wait_done = ({1'b0, wait_ff} + 17'd1) >= {1'b0, wait_lim};

      ramp_done = 1'b0;
      if ({1'b0, throttle_ff} > {1'b0, goal_ff} + 9'd1) begin
         ramp_val = throttle_ff - 8'd1;
      end else if ({1'b0, goal_ff} > {1'b0, throttle_ff} + 9'd1) begin
         ramp_val = throttle_ff + 8'd1;
      end else begin
         ramp_val  = goal_ff;
         ramp_done = 1'b1;
      end

      rate      = (cfg.sweep_rate == 16'd0) ? 16'd1 : cfg.sweep_rate;
      top       = ANGLE_W'(21'(cfg.revolutions) * 21'(REV_UNITS));
      up_sum    = {1'b0, sweep_pos_ff} + 29'(rate);
      up_val    = up_sum[ANGLE_W] ? ANGLE_MAX : up_sum[ANGLE_W-1:0];
      angle_inc = (cfg.angle_increment == 9'd0) ? 9'd1 : cfg.angle_increment;
      angle_next = {1'b0, step_angle_ff} + {1'b0, angle_inc};
      rev_next  = rev_cnt_ff + 8'd1;
   end

   always_comb begin
      phase_in        = phase_ff;
      motor_in        = motor_ff;
      throttle_in     = throttle_ff;
      goal_in         = goal_ff;
      level_in        = level_ff;
      rev_cnt_in      = rev_cnt_ff;
      step_angle_in   = step_angle_ff;
      sweep_pos_in    = sweep_pos_ff;
      wait_in         = wait_ff;
      go_level        = 1'b0;
      level_pct       = 8'd0;
      clr_revs        = 1'b0;
      rev_inc         = 1'b0;
      pos_angle       = 9'd0;
      angle_we        = 1'b0;
      angle_from_step = 1'b0;
      angle_wd        = '0;
      clr_angles      = 1'b0;
      stamp           = 1'b0;

      if (phase_ff != PH_DONE && stop_request) begin
         phase_in    = PH_DONE;
         throttle_in = '0;
         goal_in     = '0;
         wait_in     = '0;
         clr_angles  = 1'b1;
      end else begin
         case (phase_ff)
            PH_START: begin
               wait_in = wait_done ? 16'd0 : wait_ff + 16'd1;
               if (wait_done) begin
                  motor_in  = '0;
                  clr_revs  = 1'b1;
                  go_level  = 1'b1;
                  level_pct = {1'b0, cfg.throttle_begin};
               end
            end
            PH_RAMP_UP: begin
               throttle_in = ramp_val;
               if (ramp_done) begin
                  if (cfg.sweep_mode) begin
                     phase_in = PH_SETTLE_LOW;
                  end else begin
                     angle_we        = 1'b1;
                     angle_from_step = 1'b1;
                     phase_in        = PH_PRE_DWELL;
                  end
               end
            end
            PH_PRE_DWELL: begin
               wait_in = wait_done ? 16'd0 : wait_ff + 16'd1;
               if (wait_done) begin
                  if (cfg.revolutions == 8'd0) begin
                     go_level  = 1'b1;
                     level_pct = {1'b0, level_ff} +
                                 ((cfg.throttle_increment == 7'd0) ? 8'd1 :
                                  {1'b0, cfg.throttle_increment});
                  end else begin
                     rev_cnt_in      = '0;
                     step_angle_in   = '0;
                     angle_we        = 1'b1;
                     angle_from_step = 1'b1;
                     phase_in        = PH_STEP_DWELL;
                  end
               end
            end
            PH_STEP_DWELL: begin
               wait_in = wait_done ? 16'd0 : wait_ff + 16'd1;
               if (wait_done) begin
                  stamp = 1'b1;
                  if (angle_next < {1'b0, DEG_PER_REV}) begin
                     step_angle_in   = angle_next[8:0];
                     pos_angle       = angle_next[8:0];
                     angle_we        = 1'b1;
                     angle_from_step = 1'b1;
                  end else begin
                     rev_inc    = 1'b1;
                     rev_cnt_in = rev_next;
                     if (rev_next < cfg.revolutions) begin
                        step_angle_in   = '0;
                        angle_we        = 1'b1;
                        angle_from_step = 1'b1;
                     end else begin
                        go_level  = 1'b1;
                        level_pct = {1'b0, level_ff} +
                                    ((cfg.throttle_increment == 7'd0) ? 8'd1 :
                                     {1'b0, cfg.throttle_increment});
                     end
                  end
               end
            end
            PH_RAMP_DOWN: begin
               throttle_in = ramp_val;
               if (ramp_done) begin
                  if (!cfg.sweep_mode) begin
                     angle_we        = 1'b1;
                     angle_from_step = 1'b1;
                  end
                  if ({1'b0, motor_ff} + 4'd1 < 4'(MOTOR_COUNT)) begin
                     motor_in  = motor_ff + MOTOR_W'(1);
                     clr_revs  = 1'b1;
                     go_level  = 1'b1;
                     level_pct = {1'b0, cfg.throttle_begin};
                  end else if (!cfg.sweep_mode) begin
                     phase_in = PH_END_WAIT;
                  end else begin
                     phase_in    = PH_DONE;
                     throttle_in = '0;
                     goal_in     = '0;
                     wait_in     = '0;
                     clr_angles  = 1'b1;
                  end
               end
            end
            PH_END_WAIT: begin
               wait_in = wait_done ? 16'd0 : wait_ff + 16'd1;
               if (wait_done) begin
                  phase_in    = PH_DONE;
                  throttle_in = '0;
                  goal_in     = '0;
                  wait_in     = '0;
                  clr_angles  = 1'b1;
               end
            end
            PH_SETTLE_LOW: begin
               wait_in = wait_done ? 16'd0 : wait_ff + 16'd1;
               if (wait_done) begin
                  stamp        = 1'b1;
                  sweep_pos_in = '0;
                  angle_we     = 1'b1;
                  angle_wd     = '0;
                  phase_in     = PH_SWEEP_UP;
               end
            end
            PH_SWEEP_UP: begin
               angle_we = 1'b1;
               if (up_val >= top) begin
                  sweep_pos_in = top;
                  angle_wd     = top;
                  phase_in     = PH_SETTLE_TOP;
               end else begin
                  sweep_pos_in = up_val;
                  angle_wd     = up_val;
               end
            end
            PH_SETTLE_TOP: begin
               wait_in = wait_done ? 16'd0 : wait_ff + 16'd1;
               if (wait_done) begin
                  stamp    = 1'b1;
                  angle_we = 1'b1;
                  angle_wd = sweep_pos_ff;
                  phase_in = PH_SWEEP_DOWN;
               end
            end
            PH_SWEEP_DOWN: begin
               angle_we = 1'b1;
               if (sweep_pos_ff <= ANGLE_W'(rate)) begin
                  sweep_pos_in = '0;
                  angle_wd     = '0;
                  go_level     = 1'b1;
                  level_pct    = {1'b0, level_ff} +
                                 ((cfg.throttle_increment == 7'd0) ? 8'd1 :
                                  {1'b0, cfg.throttle_increment});
               end else begin
                  sweep_pos_in = sweep_pos_ff - ANGLE_W'(rate);
                  angle_wd     = sweep_pos_ff - ANGLE_W'(rate);
               end
            end
            default: begin
            end
         endcase
      end

      // revolution base in degrees, kept in step with total_revs
      if (rev_inc && total_revs_ff != 16'hFFFF) begin
         rev_base_cur  = rev_base_ff + 25'(DEG_PER_REV);
         total_revs_in = total_revs_ff + 16'd1;
      end else begin
         rev_base_cur  = rev_base_ff;
         total_revs_in = total_revs_ff;
      end
      pos_sum  = {1'b0, rev_base_cur} + 26'(pos_angle);
      step_val = (pos_sum[25:24] != 2'b00) ? ANGLE_MAX : {pos_sum[23:0], 4'b0000};
      if (angle_from_step) begin
         angle_wd = step_val;
      end
      rev_base_in = rev_base_cur;
      if (clr_revs) begin
         rev_base_in   = '0;
         total_revs_in = '0;
      end

      if (go_level) begin
         if (level_pct > {1'b0, cfg.throttle_final}) begin
            goal_in  = '0;
            phase_in = PH_RAMP_DOWN;
         end else begin
            level_in = level_pct[6:0];
            goal_in  = (level_pct > 8'd100) ? THROTTLE_MAX : {level_pct[6:0], 1'b0};
            phase_in = PH_RAMP_UP;
         end
      end

      for (int i = 0; i < MOTOR_COUNT; i++) begin
         if (clr_angles) begin
            held_in[i] = '0;
         end else if (angle_we && motor_ff == MOTOR_W'(i)) begin
            held_in[i] = angle_wd;
         end else begin
            held_in[i] = held_ff[i];
         end
      end

      res.motor_index    = motor_in;
      res.throttle_level = throttle_in;
      res.arm_angle      = held_in[motor_in];
      res.stamp_pulse    = stamp;
      res.done_res       = (phase_in == PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         motor_ff      <= '0;
         throttle_ff   <= '0;
         goal_ff       <= '0;
         level_ff      <= '0;
         rev_cnt_ff    <= '0;
         total_revs_ff <= '0;
         rev_base_ff   <= '0;
         step_angle_ff <= '0;
         sweep_pos_ff  <= '0;
         wait_ff       <= '0;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            held_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff      <= phase_in;
         motor_ff      <= motor_in;
         throttle_ff   <= throttle_in;
         goal_ff       <= goal_in;
         level_ff      <= level_in;
         rev_cnt_ff    <= rev_cnt_in;
         total_revs_ff <= total_revs_in;
         rev_base_ff   <= rev_base_in;
         step_angle_ff <= step_angle_in;
         sweep_pos_ff  <= sweep_pos_in;
         wait_ff       <= wait_in;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
   end

endmodule

@@ src/motor_arm_calibration_sweep.sv @@
`timescale 1ns / 1ps
// channel   direction  transfer when             payload
// req_      in         req_valid & !req_stall    req_stop_request
// rsp_      out        rsp_valid & !rsp_stall    motor_index, throttle_level, arm_angle,
//                                                stamp_pulse, done_res
// csr_      in/out     psel & penable & pwrite   8 registers at byte address 4*i
//
// one tick per cycle while req_stall is low: the sequencer state and the result
// register load on the same edge, so a tick can follow every cycle.
// req_stall rises only while a result sits in the output register and rsp_stall is high.
// synchronous reset puts the sequencer in its start delay with all angles zero
// and loads the register defaults.
module motor_arm_calibration_sweep
   import macs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_stop_request,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MOTOR_W-1:0]    rsp_motor_index,
   output logic [THROTTLE_W-1:0] rsp_throttle_level,
   output logic [ANGLE_W-1:0]    rsp_arm_angle,
   output logic                  rsp_stamp_pulse,
   output logic                  rsp_done_res,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic [2:0] REG_SWEEP_MODE   = 3'd0;
   localparam logic [2:0] REG_THR_BEGIN    = 3'd1;
   localparam logic [2:0] REG_THR_INC      = 3'd2;
   localparam logic [2:0] REG_THR_FINAL    = 3'd3;
   localparam logic [2:0] REG_REVOLUTIONS  = 3'd4;
   localparam logic [2:0] REG_ANGLE_INC    = 3'd5;
   localparam logic [2:0] REG_DWELL_TICKS  = 3'd6;
   localparam logic [2:0] REG_SWEEP_RATE   = 3'd7;

   cfg_type cfg_ff;
   res_type res_in;
   res_type res_ff;
   logic    rsp_valid_ff;
   logic    slot_free;
   logic    accept;
   logic    csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_mode         <= 1'b0;
         cfg_ff.throttle_begin     <= 7'd0;
         cfg_ff.throttle_increment <= 7'd10;
         cfg_ff.throttle_final     <= 7'd100;
         cfg_ff.revolutions        <= 8'd1;
         cfg_ff.angle_increment    <= 9'd30;
         cfg_ff.dwell_ticks        <= 16'd100;
         cfg_ff.sweep_rate         <= 16'd57;
      end else if (csr_write) begin
         case (csr_index)
            REG_SWEEP_MODE:  cfg_ff.sweep_mode         <= csr_pwdata[0];
            REG_THR_BEGIN:   cfg_ff.throttle_begin     <= csr_pwdata[6:0];
            REG_THR_INC:     cfg_ff.throttle_increment <= csr_pwdata[6:0];
            REG_THR_FINAL:   cfg_ff.throttle_final     <= csr_pwdata[6:0];
            REG_REVOLUTIONS: cfg_ff.revolutions        <= csr_pwdata[7:0];
            REG_ANGLE_INC:   cfg_ff.angle_increment    <= csr_pwdata[8:0];
            REG_DWELL_TICKS: cfg_ff.dwell_ticks        <= csr_pwdata[15:0];
            REG_SWEEP_RATE:  cfg_ff.sweep_rate         <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SWEEP_MODE:  csr_prdata = 32'(cfg_ff.sweep_mode);
         REG_THR_BEGIN:   csr_prdata = 32'(cfg_ff.throttle_begin);
         REG_THR_INC:     csr_prdata = 32'(cfg_ff.throttle_increment);
         REG_THR_FINAL:   csr_prdata = 32'(cfg_ff.throttle_final);
         REG_REVOLUTIONS: csr_prdata = 32'(cfg_ff.revolutions);
         REG_ANGLE_INC:   csr_prdata = 32'(cfg_ff.angle_increment);
         REG_DWELL_TICKS: csr_prdata = 32'(cfg_ff.dwell_ticks);
         REG_SWEEP_RATE:  csr_prdata = 32'(cfg_ff.sweep_rate);
         default:         csr_prdata = 32'd0;
      endcase
   end

   // output register frees up on the same edge its result transfers
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !slot_free;
   assign accept    = req_valid && slot_free;

   macs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .stop_request (req_stop_request),
      .cfg          (cfg_ff),
      .res          (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_index    = res_ff.motor_index;
   assign rsp_throttle_level = res_ff.throttle_level;
   assign rsp_arm_angle      = res_ff.arm_angle;
   assign rsp_stamp_pulse    = res_ff.stamp_pulse;
   assign rsp_done_res       = res_ff.done_res;

endmodule
